FILE: design/adq_pkg.sv
package adq_pkg;

   // Field and register widths
   localparam int SAMPLE_W  = 16;
   localparam int CODE_W    = 16;
   localparam int PHI_W     = 15;
   localparam int LEAK_W    = 16;
   localparam int WL_W      = 5;
   localparam int CMAX_W    = 15;
   localparam int STEP_W    = 15;
   localparam int MAG_W     = 16;
   localparam int SUM_W     = 32;
   localparam int SCALED_W  = SUM_W - 15;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 16;

   // Shared divider geometry
   localparam int DIV_NUM_W = 17;
   localparam int DIV_DEN_W = 16;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

   localparam logic [STEP_W-1:0] STEP_TOP  = 15'd32766;
   localparam logic [STEP_W-1:0] STEP_ONE  = 15'd1;
   localparam logic [PHI_W-1:0]  PHI_RESET = 15'd16384;
   localparam logic [WL_W-1:0]   WL_RESET  = 5'd10;
   localparam logic [CMAX_W-1:0] CMAX_RESET = 15'd7;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PHI_GAIN      = 4'd0,
      CSR_LEAK_COEFF    = 4'd1,
      CSR_WINDOW_LENGTH = 4'd2,
      CSR_CODE_MAX      = 4'd3
   } adq_csr_type;

   typedef struct packed {
      logic [PHI_W-1:0]         phi_gain;
      logic signed [LEAK_W-1:0] leak_coeff;
      logic [WL_W-1:0]          window_length;
      logic [CMAX_W-1:0]        code_max;
   } adq_cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_QSTART,
      ST_QDIV,
      ST_MULT,
      ST_RECON,
      ST_SUM,
      ST_PHI,
      ST_SSTART,
      ST_SDIV,
      ST_OUT
   } adq_state_type;

   typedef struct packed {
      logic capture;
      logic diff;
      logic div_start;
      logic div_sel_step;
      logic quant;
      logic mult;
      logic recon;
      logic sum;
      logic phi;
      logic step;
      logic out_load;
   } adq_cmd_type;

   typedef struct packed {
      logic div_done;
      logic rsp_busy;
   } adq_status_type;

endpackage

FILE: design/adq_divider.sv
module adq_divider
   import adq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] dividend,
   input  logic [DIV_DEN_W-1:0] divisor,
   output logic                 done,
   output logic [DIV_NUM_W-1:0] quotient
);

   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_DEN_W:0]   trial;
   logic                 fits;

   // One quotient bit per cycle, restoring
   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_NUM_W-1]};
      fits    = trial >= {1'b0, den_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = DIV_CNT_W'(DIV_NUM_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? DIV_DEN_W'(trial - {1'b0, den_ff}) : trial[DIV_DEN_W-1:0];
         quo_in = {quo_ff[DIV_NUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (start) begin
         den_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: design/adq_datapath.sv
module adq_datapath
   import adq_pkg::*;
#(
   parameter int MAX_WINDOW = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  adq_cfg_type                cfg,
   input  adq_cmd_type                cmd,
   output adq_status_type             status,
   input  logic signed [SAMPLE_W-1:0] sample_in,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [CODE_W-1:0]   rsp_code_out
);

   localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int LIM_W = ($clog2(MAX_WINDOW + 1) > WL_W) ? $clog2(MAX_WINDOW + 1) : WL_W;

   // Architectural state
   logic signed [SAMPLE_W-1:0] pred_ff;
   logic signed [SAMPLE_W-1:0] last_recon_ff;
   logic [STEP_W-1:0]          step_ff;
   logic [SUM_W-1:0]           sum_ff;
   logic [IDX_W-1:0]           idx_ff;
   logic [MAX_WINDOW-1:0]      valid_ff;
   logic [MAG_W-1:0]           store_mem [MAX_WINDOW];

   // Per-item working registers
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic                       neg_ff;
   logic [MAG_W-1:0]           dmag_ff;
   logic signed [31:0]         leak_prod_ff;
   logic signed [CODE_W-1:0]   code_ff;
   logic signed [SAMPLE_W-1:0] dq_ff;
   logic signed [SAMPLE_W-1:0] leak_ff;
   logic signed [SAMPLE_W-1:0] recon_ff;
   logic [MAG_W-1:0]           mag_ff;
   logic [MAG_W-1:0]           rd_data_ff;
   logic                       rd_valid_ff;
   logic [SCALED_W-1:0]        scaled_ff;
   logic                       rsp_valid_ff;
   logic signed [CODE_W-1:0]   rsp_code_ff;

   logic signed [SAMPLE_W-1:0] diff;
   logic signed [31:0]         leak_prod;
   logic signed [31:0]         leak_adj;
   logic signed [31:0]         leak_q;
   logic signed [SAMPLE_W-1:0] step_s;
   logic signed [31:0]         dq_prod;
   logic [SUM_W+PHI_W-1:0]     phi_prod;
   logic [DIV_NUM_W-1:0]       div_num;
   logic [DIV_DEN_W-1:0]       div_den;
   logic                       div_done;
   logic [DIV_NUM_W-1:0]       div_quo;
   logic [DIV_NUM_W-1:0]       code_lim;
   logic [DIV_NUM_W-1:0]       code_mag;
   logic signed [CODE_W-1:0]   code_val;
   logic [STEP_W-1:0]          step_val;
   logic [MAG_W-1:0]           old_val;
   logic [LIM_W-1:0]           limit;
   logic [LIM_W-1:0]           idx_next;

   assign diff      = sample_ff - pred_ff;
   assign leak_prod = cfg.leak_coeff * last_recon_ff;
   assign leak_adj  = leak_prod_ff + (leak_prod_ff[31] ? 32'sd32767 : 32'sd0);
   assign leak_q    = leak_adj >>> 15;
   assign step_s    = {1'b0, step_ff};
   assign dq_prod   = code_ff * step_s;
   assign phi_prod  = sum_ff * cfg.phi_gain;
   assign old_val   = rd_valid_ff ? rd_data_ff : '0;

   assign div_num = cmd.div_sel_step ? DIV_NUM_W'(scaled_ff) : {1'b0, dmag_ff};
   assign div_den = cmd.div_sel_step ? DIV_DEN_W'(cfg.window_length) : {1'b0, step_ff};

   adq_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Saturate quotient into the code range
   always_comb begin
      code_lim = neg_ff ? DIV_NUM_W'(cfg.code_max) + 1'b1 : DIV_NUM_W'(cfg.code_max);
      code_mag = (div_quo > code_lim) ? code_lim : div_quo;
      code_val = neg_ff ? CODE_W'(0 - code_mag) : code_mag[CODE_W-1:0];
   end

   always_comb begin
      if (cfg.window_length == '0) begin
         step_val = STEP_TOP;
      end else if (div_quo == '0) begin
         step_val = STEP_ONE;
      end else if (div_quo > DIV_NUM_W'(STEP_TOP)) begin
         step_val = STEP_TOP;
      end else begin
         step_val = div_quo[STEP_W-1:0];
      end
   end

   always_comb begin
      limit    = (LIM_W'(cfg.window_length) < LIM_W'(MAX_WINDOW)) ?
                 LIM_W'(cfg.window_length) : LIM_W'(MAX_WINDOW);
      idx_next = LIM_W'(idx_ff) + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pred_ff       <= '0;
         last_recon_ff <= '0;
         step_ff       <= STEP_ONE;
         sum_ff        <= '0;
         idx_ff        <= '0;
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.sum) begin
            pred_ff          <= recon_ff - leak_ff;
            last_recon_ff    <= recon_ff;
            sum_ff           <= sum_ff - SUM_W'(old_val) + SUM_W'(mag_ff);
            valid_ff[idx_ff] <= 1'b1;
         end
         if (cmd.phi) begin
            idx_ff <= (idx_next >= limit) ? '0 : IDX_W'(idx_next);
         end
         if (cmd.step) begin
            step_ff <= step_val;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sum) begin
         store_mem[idx_ff] <= mag_ff;
      end
      rd_data_ff  <= store_mem[idx_ff];
      rd_valid_ff <= valid_ff[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff <= sample_in;
      end
      if (cmd.diff) begin
         neg_ff       <= !(diff > 0);
         dmag_ff      <= (diff > 0) ? MAG_W'(diff) : MAG_W'(0 - diff);
         leak_prod_ff <= leak_prod;
      end
      if (cmd.quant) begin
         code_ff <= code_val;
      end
      if (cmd.mult) begin
         dq_ff   <= dq_prod[SAMPLE_W-1:0];
         leak_ff <= leak_q[SAMPLE_W-1:0];
      end
      if (cmd.recon) begin
         recon_ff <= dq_ff + pred_ff;
         mag_ff   <= dq_ff[SAMPLE_W-1] ? MAG_W'(0 - dq_ff) : MAG_W'(dq_ff);
      end
      if (cmd.phi) begin
         scaled_ff <= phi_prod[SUM_W-1:15];
      end
      if (cmd.out_load) begin
         rsp_code_ff <= code_ff;
      end
   end

   assign status.div_done = div_done;
   assign status.rsp_busy = rsp_valid_ff && rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_code_out    = rsp_code_ff;

endmodule

FILE: design/adq_controller.sv
module adq_controller
   import adq_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  adq_status_type status,
   output adq_cmd_type    cmd
);

   adq_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DIFF;
            end
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_QSTART;
         end
         ST_QSTART: begin
            cmd.div_start = 1'b1;
            state_in      = ST_QDIV;
         end
         ST_QDIV: begin
            if (status.div_done) begin
               cmd.quant = 1'b1;
               state_in  = ST_MULT;
            end
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_RECON;
         end
         ST_RECON: begin
            cmd.recon = 1'b1;
            state_in  = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_PHI;
         end
         ST_PHI: begin
            cmd.phi  = 1'b1;
            state_in = ST_SSTART;
         end
         ST_SSTART: begin
            cmd.div_start    = 1'b1;
            cmd.div_sel_step = 1'b1;
            state_in         = ST_SDIV;
         end
         ST_SDIV: begin
            cmd.div_sel_step = 1'b1;
            if (status.div_done) begin
               cmd.step = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!status.rsp_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: design/adaptive_differential_quantizer_top.sv
// Channel   Direction  Ports                              Moves
// req       in         req_valid, req_stall, req_sample_in  one sample per transaction
// rsp       out        rsp_valid, rsp_stall, rsp_code_out   one code per transaction
// csr       in         csr_valid, csr_ready, csr_index,     one register write
//                      csr_wdata
//
// With no stall a code is valid after two passes of the shared restoring divider
// (17 steps each, then a done strobe) and the control states around them.
// The block can take the next sample in the cycle after the code is loaded, even while
// it waits under rsp_stall; a stalled older code holds the load, and with it the next sample.
// Reset clears the prediction, running sum, ring valid bits and index, sets the step size
// to one and loads register defaults. csr is always ready; write it only when idle.
module adaptive_differential_quantizer_top
   import adq_pkg::*;
#(
   parameter int MAX_WINDOW = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [SAMPLE_W-1:0]  req_sample_in,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [CODE_W-1:0]    rsp_code_out,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DAT_W-1:0]        csr_wdata
);

   adq_cfg_type    cfg_ff;
   adq_cmd_type    cmd;
   adq_status_type status;

   assign csr_ready = 1'b1;

   // Register file: decode the index, drop writes past the last register
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phi_gain      <= PHI_RESET;
         cfg_ff.leak_coeff    <= '0;
         cfg_ff.window_length <= WL_RESET;
         cfg_ff.code_max      <= CMAX_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PHI_GAIN:      cfg_ff.phi_gain      <= csr_wdata[PHI_W-1:0];
            CSR_LEAK_COEFF:    cfg_ff.leak_coeff    <= $signed(csr_wdata[LEAK_W-1:0]);
            CSR_WINDOW_LENGTH: cfg_ff.window_length <= csr_wdata[WL_W-1:0];
            CSR_CODE_MAX:      cfg_ff.code_max      <= csr_wdata[CMAX_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Sequencer: walks each item through diff, divide, reconstruct, adapt
   adq_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic, ring store and output register
   adq_datapath #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .cmd          (cmd),
      .status       (status),
      .sample_in    (req_sample_in),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_code_out (rsp_code_out)
   );

endmodule

FILE: test/adaptive_differential_quantizer_top_tb.sv
`timescale 1ns / 100ps

module adaptive_differential_quantizer_top_tb
   import adq_pkg::*;
();

   localparam int RING_DEPTH     = 16;
   localparam int RANDOM_PHASES  = 12;
   localparam int PHASE_SAMPLES  = 152;
   localparam int QUIET_CYCLES   = 8;
   localparam int TAIL_CYCLES    = 100;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int REPORT_LIMIT   = 10;

   // Index past the register list: the block must drop such a write.
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 4'd11;

   // ------------------------------------------------------------------
   // Code predictor and scoreboard. Keeps its own copy of the encoder
   // state and registers, and a queue of codes still owed by the block.
   // ------------------------------------------------------------------
   class adq_code_scoreboard;
      typedef struct {
         int                        seq;
         logic signed [CODE_W-1:0]  code;
      } owed_code_type;

      // register copy
      bit [PHI_W-1:0]  phi;
      int              leak;
      bit [WL_W-1:0]   wlen;
      bit [CMAX_W-1:0] cmax;

      // encoder state
      int              step_q;
      int              pred;
      int              last_recon;
      bit [SUM_W-1:0]  ring_sum;
      bit [MAG_W-1:0]  ring [RING_DEPTH];
      int unsigned     ring_pos;

      owed_code_type   owed_codes[$];

      int samples_seen;
      int codes_checked;
      int failures;
      int clipped_codes;
      int step_at_top;
      int reg_writes;

      function new();
         phi        = PHI_RESET;
         leak       = 0;
         wlen       = WL_RESET;
         cmax       = CMAX_RESET;
         step_q     = int'(STEP_ONE);
         pred       = 0;
         last_recon = 0;
         ring_sum   = '0;
         ring_pos   = 0;
         foreach (ring[i]) ring[i] = '0;
      endfunction

      function int fold16(int v);
         logic signed [15:0] t;
         t = v[15:0];
         return int'(t);
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] data);
         reg_writes++;
         case (idx)
            CSR_PHI_GAIN:      phi  = data[PHI_W-1:0];
            CSR_LEAK_COEFF:    leak = int'($signed(data[LEAK_W-1:0]));
            CSR_WINDOW_LENGTH: wlen = data[WL_W-1:0];
            CSR_CODE_MAX:      cmax = data[CMAX_W-1:0];
            default: ;
         endcase
      endfunction

      // Advance the encoder by one accepted sample and queue its code.
      function void note_sample(logic signed [SAMPLE_W-1:0] smp);
         int             stp;
         int             diff;
         int             q;
         int             dq;
         int             recon;
         int             leak_term;
         int unsigned    slot;
         int unsigned    span;
         bit [SUM_W-1:0] mag;
         bit [SUM_W-1:0] product;
         bit [SUM_W-1:0] scaled;
         bit [SUM_W-1:0] quot;
         owed_code_type  item;

         stp  = (step_q < 1) ? 1 : step_q;
         diff = fold16(int'(smp) - pred);
         if (diff > 0) begin
            q = diff / stp;
            if (q >= int'(cmax)) begin
               if (q > int'(cmax)) clipped_codes++;
               q = int'(cmax);
            end
         end else begin
            q = -((-diff) / stp);
            if (q < -int'(cmax) - 1) begin
               clipped_codes++;
               q = -int'(cmax) - 1;
            end
         end
         dq        = fold16(q * stp);
         recon     = fold16(dq + pred);
         leak_term = (leak * last_recon) / 32768;
         mag       = (dq < 0) ? SUM_W'(-dq) : SUM_W'(dq);
         slot      = (ring_pos < RING_DEPTH) ? ring_pos : 0;

         item.seq  = samples_seen;
         item.code = q[CODE_W-1:0];
         owed_codes.push_back(item);
         samples_seen++;

         pred       = fold16(recon - leak_term);
         last_recon = recon;

         ring_sum   = ring_sum - SUM_W'(ring[slot]) + mag;
         ring[slot] = mag[MAG_W-1:0];

         product = ring_sum * SUM_W'(phi);
         scaled  = product >> 15;
         if (wlen == 0) begin
            step_q = int'(STEP_TOP);
         end else begin
            quot = scaled / SUM_W'(wlen);
            if (quot < 1) quot = 1;
            if (quot > SUM_W'(STEP_TOP)) quot = SUM_W'(STEP_TOP);
            step_q = int'(quot);
         end
         if (step_q == int'(STEP_TOP)) step_at_top++;

         span = (wlen < RING_DEPTH) ? int'(wlen) : RING_DEPTH;
         slot++;
         if (slot >= span) slot = 0;
         ring_pos = slot;
      endfunction

      function void check_code(logic signed [CODE_W-1:0] actual);
         owed_code_type item;
         codes_checked++;
         if (owed_codes.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("[%0t] unexpected code %0d with no sample outstanding", $realtime,
                        actual);
            return;
         end
         item = owed_codes.pop_front();
         if (actual !== item.code) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("[%0t] code_out of sample %0d: expected %0d, got %0d", $realtime,
                        item.seq, item.code, actual);
         end
      endfunction

      function int pending();
         return owed_codes.size();
      endfunction
   endclass

   // ------------------------------------------------------------------
   // Block under test
   // ------------------------------------------------------------------
   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample_in;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic signed [CODE_W-1:0]   rsp_code_out;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [CSR_DAT_W-1:0]       csr_wdata;

   adaptive_differential_quantizer_top #(
      .MAX_WINDOW(RING_DEPTH)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_sample_in(req_sample_in),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_code_out (rsp_code_out),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   adq_code_scoreboard sb = new();

   logic signed [SAMPLE_W-1:0] last_sample = '0;
   int                         settings_used = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Random shaping
   // ------------------------------------------------------------------

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Speech-like walk most of the time, with jumps, noise and rail values
   // mixed in so the difference wraps and the quantizer saturates.
   function automatic logic signed [SAMPLE_W-1:0] next_sample();
      int r;
      logic signed [SAMPLE_W-1:0] s;
      r = $urandom_range(0, 99);
      if (r < 45)
         s = last_sample + SAMPLE_W'(int'($urandom_range(0, 512)) - 256);
      else if (r < 60)
         s = last_sample + SAMPLE_W'(int'($urandom_range(0, 8192)) - 4096);
      else if (r < 88)
         s = SAMPLE_W'($urandom);
      else begin
         case ($urandom_range(0, 3))
            0:       s = 16'sh7FFF;
            1:       s = 16'sh8000;
            2:       s = '0;
            default: s = -16'sd1;
         endcase
      end
      last_sample = s;
      return s;
   endfunction

   function automatic logic [PHI_W-1:0] pick_phi();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return 15'h7FFF;
         2:       return PHI_RESET;
         3:       return PHI_W'($urandom_range(1, 1024));
         default: return PHI_W'($urandom);
      endcase
   endfunction

   function automatic logic [LEAK_W-1:0] pick_leak();
      case ($urandom_range(0, 4))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return '0;
         default: return LEAK_W'($urandom);
      endcase
   endfunction

   // Lengths of zero and above the ring depth are legal register values too.
   function automatic logic [WL_W-1:0] pick_wlen();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 5'd1;
         2:       return 5'd16;
         3:       return WL_W'($urandom_range(17, 31));
         default: return WL_W'($urandom_range(2, 15));
      endcase
   endfunction

   function automatic logic [CMAX_W-1:0] pick_cmax();
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return 15'h7FFF;
         2:       return CMAX_RESET;
         3:       return CMAX_W'($urandom_range(1, 15));
         default: return CMAX_W'($urandom);
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------

   // Offer one sample after an optional gap and hold it until taken.
   // Valid is left high after the transaction so back-to-back samples
   // never see a low/high pair in the same step.
   task automatic feed_sample(input logic signed [SAMPLE_W-1:0] smp, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= smp;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_sample(smp);
   endtask

   // One register write; csr_valid drops after it to separate it from the next.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DAT_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.write_reg(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Program all four registers. Unused upper data bits carry junk, which
   // the block must drop.
   task automatic apply_setting(input logic [PHI_W-1:0] phi, input logic [LEAK_W-1:0] leak,
                                input logic [WL_W-1:0] wlen, input logic [CMAX_W-1:0] cmax);
      if ($urandom_range(0, 2) == 0)
         write_csr(CSR_UNMAPPED, CSR_DAT_W'($urandom));
      write_csr(CSR_PHI_GAIN,      {1'($urandom), phi});
      write_csr(CSR_LEAK_COEFF,    leak);
      write_csr(CSR_WINDOW_LENGTH, {11'($urandom), wlen});
      write_csr(CSR_CODE_MAX,      {1'($urandom), cmax});
      settings_used++;
   endtask

   // Drop valid and wait until every owed code has come back, then idle briefly
   // so register writes land on a quiet block.
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic feed_list(input logic signed [SAMPLE_W-1:0] list[$]);
      foreach (list[i]) feed_sample(list[i], pick_gap());
      settle();
   endtask

   // ------------------------------------------------------------------
   // Result side: random back-pressure with long stall-free stretches,
   // and a monitor that checks each accepted transaction.
   // ------------------------------------------------------------------
   initial begin
      int open_len;
      int hold_len;
      rsp_stall <= 1'b0;
      forever begin
         open_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                                : $urandom_range(1, 8);
         repeat (open_len) @(posedge clock);
         hold_len = pick_gap();
         if (hold_len > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_len) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         sb.check_code(rsp_code_out);
   end

   // Watchdog: count cycles with no transaction on any channel.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset !== 1'b0 ||
          (req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0) ||
          (csr_valid === 1'b1 && csr_ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("[%0t] watchdog: no transaction for %0d cycles, %0d codes outstanding",
                  $realtime, WATCHDOG_LIMIT, sb.pending());
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin
      logic [PHI_W-1:0]  phi;
      logic [LEAK_W-1:0] leak;
      logic [WL_W-1:0]   wlen;
      logic [CMAX_W-1:0] cmax;
      bit                tight;

      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_sample_in <= '0;
      csr_valid     <= 1'b0;
      csr_index     <= CSR_PHI_GAIN;
      csr_wdata     <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset defaults: step of one and a code range of [-8, 7], so rail
      // samples saturate both ways.
      feed_list('{16'sd0, 16'sh7FFF, 16'sh8000, -16'sd1, 16'sd1, 16'sd1000, -16'sd1000,
                  16'sh5555, 16'shAAAA});

      // Zero gain pins the step at one; full code range lets the difference
      // hit -32768, the largest magnitude, and wrap across the rails.
      apply_setting('0, '0, 5'd1, 15'h7FFF);
      feed_list('{16'sd0, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sd0});

      // Zero window length: step goes to its ceiling; code range is [-1, 0].
      apply_setting(15'h7FFF, 16'h7FFF, 5'd0, '0);
      feed_list('{16'sd20000, -16'sd20000, 16'sd5});

      // Window length beyond the ring depth, most negative leak.
      apply_setting(PHI_RESET, 16'h8000, 5'd31, 15'd100);
      feed_list('{16'sd30000, -16'sd30000, 16'sd12, -16'sd7});

      // Shrink the window below the current ring position.
      apply_setting(PHI_RESET, 16'h2000, 5'd3, 15'd100);
      feed_list('{16'sd300, -16'sd300, 16'sd0});

      // Random phases, each under a fresh register setting.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         phi  = pick_phi();
         leak = pick_leak();
         wlen = (ph == 0) ? 5'd16 : pick_wlen();
         cmax = pick_cmax();
         apply_setting(phi, leak, wlen, cmax);
         tight = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < PHASE_SAMPLES; n++)
            feed_sample(next_sample(), tight ? 0 : pick_gap());
         settle();
      end

      // Drain, then watch a while for stray codes.
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d samples and %0d codes over %0d register settings (%0d writes).",
               sb.samples_seen, sb.codes_checked, settings_used + 1, sb.reg_writes);
      $display("Saturated codes: %0d; step size at its ceiling after %0d samples.",
               sb.clipped_codes, sb.step_at_top);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
